// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. They compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// A property that must hold at every clock edge out of reset.
`define CTR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A condition that must never be true out of reset.
`define CTR_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CTR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTR_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/ctr_pkg.sv -----
package ctr_pkg;

  // Result kinds.
  typedef enum logic [2:0] {
    RK_PAYLOAD = 3'd0,
    RK_FINAL   = 3'd1,
    RK_FLOW    = 3'd2,
    RK_TIMEOUT = 3'd3,
    RK_SEQ_ERR = 3'd4
  } res_kind_t;

  // Frame types in the upper nibble of the protocol control byte.
  localparam logic [3:0] PCI_SINGLE = 4'h0;
  localparam logic [3:0] PCI_FIRST  = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RX_IDENT = 2'd0;
  localparam logic [1:0] CFG_TX_IDENT = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

  // Protocol constants.
  localparam logic [7:0]  FC_CTS         = 8'h30;
  localparam logic [2:0]  FC_BYTES       = 3'd3;
  localparam logic [2:0]  SF_MAX_LEN     = 3'd7;
  localparam logic [11:0] FF_MAX_BYTES   = 12'd6;
  localparam logic [11:0] CF_BYTES       = 12'd7;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd250;
  localparam logic [15:0] GAP_MAX        = 16'hFFFF;
  localparam logic [3:0]  SEQ_START      = 4'd1;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One result item.
  typedef struct packed {
    res_kind_t       kind;
    logic [6:0][7:0] pay;
    logic [2:0]      byte_count;
    logic [11:0]     message_length;
    logic [10:0]     dest_ident;
    logic            run_last;
  } result_t;

endpackage

// ----- rtl/can_transport_reassembler.sv -----
// Receive-side reassembler for segmented CAN transport messages. Each input item is a
// received frame or a one-millisecond tick; results come out one per cycle while
// out_stall is low, from a four-entry result queue, the first in the cycle after the item
// is accepted. An item is taken in every cycle while the queue holds at most two results,
// so single frames, consecutive frames and ticks run at one item per cycle, and a first
// frame yields a payload result and a flow-control request; for a stream of first frames
// the sustained rate is set by the output side draining one result per cycle.
// Configuration writes take effect at once.
`include "assert_macros.svh"

module can_transport_reassembler import ctr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [10:0] in_can_ident,
  input  logic [7:0]  in_data0,
  input  logic [7:0]  in_data1,
  input  logic [7:0]  in_data2,
  input  logic [7:0]  in_data3,
  input  logic [7:0]  in_data4,
  input  logic [7:0]  in_data5,
  input  logic [7:0]  in_data6,
  input  logic [7:0]  in_data7,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [7:0]  out_pay0,
  output logic [7:0]  out_pay1,
  output logic [7:0]  out_pay2,
  output logic [7:0]  out_pay3,
  output logic [7:0]  out_pay4,
  output logic [7:0]  out_pay5,
  output logic [7:0]  out_pay6,
  output logic [2:0]  out_byte_count,
  output logic [11:0] out_message_length,
  output logic [10:0] out_dest_ident,
  output logic        out_run_last
);

  // Configuration registers.
  logic [10:0] rx_ident_r;
  logic [10:0] tx_ident_r;
  logic [15:0] timeout_r;

  // Session state.
  logic        phase_r, phase_nxt;
  logic [3:0]  seq_r, seq_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [15:0] gap_r, gap_nxt;

  // Result queue.
  result_t           q_r [QDEPTH];
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  logic              in_accept;
  logic              pop;
  logic              frame_hit;
  logic              ff_accept;
  logic [3:0]        pci_type;
  logic [3:0]        pci_low;
  logic [7:0]        d [8];
  logic [1:0]        n_res;
  logic [1:0]        push_n;
  result_t           res0, res1;
  logic [2:0]        sf_len;
  logic [11:0]       ff_len;
  logic [2:0]        ff_n;
  result_t           head;

  assign d[0] = in_data0;
  assign d[1] = in_data1;
  assign d[2] = in_data2;
  assign d[3] = in_data3;
  assign d[4] = in_data4;
  assign d[5] = in_data5;
  assign d[6] = in_data6;
  assign d[7] = in_data7;

  assign pci_type  = in_data0[7:4];
  assign pci_low   = in_data0[3:0];
  assign frame_hit = !in_kind && (in_can_ident == rx_ident_r);
  assign sf_len    = (pci_low > {1'b0, SF_MAX_LEN}) ? SF_MAX_LEN : pci_low[2:0];
  assign ff_len    = {pci_low, in_data1};
  assign ff_n      = (ff_len < FF_MAX_BYTES) ? ff_len[2:0] : FF_MAX_BYTES[2:0];

  // Handshake: room for two more results keeps the input open.
  assign in_stall  = (count_r > QCNT_W'(QDEPTH - 2));
  assign in_accept = in_valid && !in_stall;
  assign pop       = (count_r != '0) && !out_stall;
  assign ff_accept = in_accept && frame_hit && (pci_type == PCI_FIRST);

  // Decode one item into up to two results and the next session state.
  always_comb begin
    res0      = '0;
    res1      = '0;
    n_res     = 2'd0;
    phase_nxt = phase_r;
    seq_nxt   = seq_r;
    rem_nxt   = rem_r;
    gap_nxt   = gap_r;
    if (in_kind) begin
      if (gap_r != GAP_MAX) begin
        gap_nxt = gap_r + 16'd1;
      end
    end else if (frame_hit) begin
      case (pci_type)
        PCI_SINGLE: begin
          for (int i = 0; i < 7; i++) begin
            if (3'(i) < sf_len) res0.pay[i] = d[i+1];
          end
          res0.kind           = RK_FINAL;
          res0.byte_count     = sf_len;
          res0.message_length = {9'd0, sf_len};
          res0.run_last       = 1'b1;
          n_res     = 2'd1;
          phase_nxt = 1'b0;
          seq_nxt   = SEQ_START;
          rem_nxt   = '0;
        end
        PCI_FIRST: begin
          for (int i = 0; i < 6; i++) begin
            if (3'(i) < ff_n) res0.pay[i] = d[i+2];
          end
          res0.kind           = RK_PAYLOAD;
          res0.byte_count     = ff_n;
          res0.message_length = ff_len;
          res0.run_last       = 1'b0;
          res1.kind           = RK_FLOW;
          res1.pay[0]         = FC_CTS;
          res1.byte_count     = FC_BYTES;
          res1.message_length = ff_len;
          res1.dest_ident     = tx_ident_r;
          res1.run_last       = 1'b1;
          n_res     = 2'd2;
          phase_nxt = 1'b1;
          seq_nxt   = SEQ_START;
          rem_nxt   = ff_len - {9'd0, ff_n};
          gap_nxt   = '0;
        end
        PCI_CONSEC: begin
          if (phase_r) begin
            n_res         = 2'd1;
            res0.run_last = 1'b1;
            if (gap_r >= timeout_r) begin
              res0.kind = RK_TIMEOUT;
              phase_nxt = 1'b0;
              seq_nxt   = SEQ_START;
              rem_nxt   = '0;
            end else begin
              gap_nxt = '0;
              if (pci_low != seq_r) begin
                res0.kind = RK_SEQ_ERR;
                phase_nxt = 1'b0;
                seq_nxt   = SEQ_START;
                rem_nxt   = '0;
              end else if (rem_r <= CF_BYTES) begin
                for (int i = 0; i < 7; i++) begin
                  if (12'(i) < rem_r) res0.pay[i] = d[i+1];
                end
                res0.kind       = RK_FINAL;
                res0.byte_count = rem_r[2:0];
                phase_nxt = 1'b0;
                seq_nxt   = SEQ_START;
                rem_nxt   = '0;
              end else begin
                for (int i = 0; i < 7; i++) begin
                  res0.pay[i] = d[i+1];
                end
                res0.kind       = RK_PAYLOAD;
                res0.byte_count = CF_BYTES[2:0];
                rem_nxt = rem_r - CF_BYTES;
                seq_nxt = seq_r + 4'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Queue pointer arithmetic.
  always_comb begin
    push_n     = in_accept ? n_res : 2'd0;
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push_n) - QCNT_W'(pop);
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_ident_r <= '0;
      tx_ident_r <= '0;
      timeout_r  <= TIMEOUT_RESET;
      phase_r    <= 1'b0;
      seq_r      <= SEQ_START;
      rem_r      <= '0;
      gap_r      <= '0;
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RX_IDENT: rx_ident_r <= cfg_data[10:0];
          CFG_TX_IDENT: tx_ident_r <= cfg_data[10:0];
          CFG_TIMEOUT:  timeout_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        phase_r <= phase_nxt;
        seq_r   <= seq_nxt;
        rem_r   <= rem_nxt;
        gap_r   <= gap_nxt;
      end
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result storage; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= res1;
    end
  end

  // Head of the queue drives the result channel.
  assign head               = q_r[rd_ptr_r];
  assign out_valid          = (count_r != '0);
  assign out_result_kind    = head.kind;
  assign out_pay0           = head.pay[0];
  assign out_pay1           = head.pay[1];
  assign out_pay2           = head.pay[2];
  assign out_pay3           = head.pay[3];
  assign out_pay4           = head.pay[4];
  assign out_pay5           = head.pay[5];
  assign out_pay6           = head.pay[6];
  assign out_byte_count     = head.byte_count;
  assign out_message_length = head.message_length;
  assign out_dest_ident     = head.dest_ident;
  assign out_run_last       = head.run_last;

  // Checks on queue occupancy and session state.
  `CTR_NEVER(a_queue_bound, clk, rst_n, count_r > QCNT_W'(QDEPTH), "result queue overfilled")
  `CTR_NEVER(a_idle_clean, clk, rst_n, !phase_r && (rem_r != '0 || seq_r != SEQ_START), "idle with stale session state")
  `CTR_ASSERT(a_ff_arms, clk, rst_n, ff_accept |=> phase_r && gap_r == '0 && seq_r == SEQ_START, "first frame did not arm the session")
  `CTR_ASSERT(a_flow_shape, clk, rst_n, (out_valid && out_result_kind == RK_FLOW) |-> (out_run_last && out_byte_count == FC_BYTES), "malformed flow-control result")

endmodule
